// ===== sv/kmg_pkg.sv =====
// ----------------------------------------------------------------------------
// kmg_pkg
// Shared widths, register map, reset values and types for the keyframe
// motion gate.
// ----------------------------------------------------------------------------
`default_nettype none

package kmg_pkg;

  // Field widths
  localparam int ROT_W    = 16;
  localparam int POS_W    = 32;
  localparam int THR_W    = 31;
  localparam int COS_W    = 16;
  localparam int TOTAL_W  = 48;

  // Distance path: squared sum and its floor root
  localparam int SQSUM_W  = 66;
  localparam int ROOT_W   = 34;

  // Register map, selected by the word address bit of paddr
  localparam int  PADDR_W      = 3;
  localparam int  PDATA_W      = 32;
  localparam logic REG_DIST_THR  = 1'b0;
  localparam logic REG_ANGLE_COS = 1'b1;

  // Register reset values
  localparam logic [THR_W-1:0] DIST_THR_RST  = 31'd1024;
  localparam logic [COS_W-1:0] ANGLE_COS_RST = 16'd14189;

  // Root unit status back to the controller
  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

endpackage

`default_nettype wire

// ===== sv/kmg_pose_if.sv =====
// ----------------------------------------------------------------------------
// kmg_pose_if
// Pose channel: valid/ready handshake carrying rotation and translation.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmg_pose_if import kmg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ROT_W-1:0] rot_00;
  logic signed [ROT_W-1:0] rot_01;
  logic signed [ROT_W-1:0] rot_02;
  logic signed [ROT_W-1:0] rot_10;
  logic signed [ROT_W-1:0] rot_11;
  logic signed [ROT_W-1:0] rot_12;
  logic signed [ROT_W-1:0] rot_20;
  logic signed [ROT_W-1:0] rot_21;
  logic signed [ROT_W-1:0] rot_22;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (
    output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
           rot_20, rot_21, rot_22, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
           rot_20, rot_21, rot_22, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/kmg_result_if.sv =====
// ----------------------------------------------------------------------------
// kmg_result_if
// Result channel: valid/ready handshake carrying the keyframe decision.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmg_result_if import kmg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [TOTAL_W-1:0] travelled;

  modport source (output valid, accepted, travelled, input ready);
  modport sink   (input valid, accepted, travelled, output ready);
endinterface

`default_nettype wire

// ===== sv/keyframe_motion_gate.sv =====
// ----------------------------------------------------------------------------
// keyframe_motion_gate
// Keyframe selection by motion threshold: compares each pose with the
// stored keyframe and passes it when translation or rotation step is large.
// ----------------------------------------------------------------------------
// Flow: serial multiply-accumulate, then the one-bit-per-cycle square root,
// decision and output register for a regular pose; the first pose goes
// straight to the decision. A new pose is taken only when the previous one
// has been decided, and the decision waits while the output register is full.
// Reset (rst, synchronous): thresholds return to 1024 and cos 14189, the
// total clears and the next pose is taken as the first keyframe.
`default_nettype none

module keyframe_motion_gate import kmg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  kmg_pose_if.sink                pose,
  kmg_result_if.source            result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int NROT  = 9;
  localparam int NPOS  = 3;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(NROT + 1);
  localparam int PROD_W = 2 * ROT_W;
  localparam int TR_W   = PROD_W + 4;
  localparam int CB_W   = COS_W + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_ROOT,
    S_DECIDE
  } state_t;

  state_t state;

  // Configuration registers
  logic [THR_W-1:0] dist_thr;
  logic [COS_W-1:0] angle_cos;

  // Pose and keyframe shift registers
  logic signed [ROT_W-1:0] rot_sr  [NROT];
  logic signed [ROT_W-1:0] key_rot [NROT];
  logic signed [POS_W-1:0] pos_sr  [NPOS];
  logic signed [POS_W-1:0] key_pos [NPOS];

  logic               first_pending;
  logic               first_item;
  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W-1:0] total;

  // Multiply-accumulate pipeline
  logic signed [PROD_W-1:0] tr_prod;
  logic                     tr_v;
  logic [POS_W-1:0]         absd;
  logic                     abs_v;
  logic [2*POS_W-1:0]       sq;
  logic                     sq_v;
  logic signed [TR_W-1:0]   tr_acc;
  logic [SQSUM_W-1:0]       sq_acc;

  // Output register
  logic               out_valid;
  logic               out_accepted;
  logic [TOTAL_W-1:0] out_travelled;

  // Root unit
  logic      sqrt_start;
  sqrt_res_t sqrt_res;

  // Combinational helpers
  logic signed [POS_W:0]  pos_diff;
  logic signed [CB_W-1:0] cos_bound;
  logic signed [TR_W-1:0] tr_bound;
  logic                   near_rot;
  logic                   near_dist;
  logic                   take_pose;
  logic [TOTAL_W:0]       total_sum;
  logic                   out_free;
  logic                   cfg_write;

  assign pose.ready = (state == S_IDLE) && !rst;
  assign out_free   = !out_valid || result.ready;
  assign sqrt_start = (state == S_MAC) && (cnt == MAC_LAST);

  // Decision terms
  always_comb begin
    pos_diff  = {pos_sr[0][POS_W-1], pos_sr[0]} - {key_pos[0][POS_W-1], key_pos[0]};
    cos_bound = CB_W'(signed'(18'sd16384))
              + {angle_cos[COS_W-1], angle_cos, 1'b0};
    tr_bound  = {{(TR_W-CB_W-14){cos_bound[CB_W-1]}}, cos_bound, 14'b0};
    near_rot  = tr_acc > tr_bound;
    near_dist = sqrt_res.root < {{(ROOT_W-THR_W){1'b0}}, dist_thr};
    take_pose = first_item || !(near_dist && near_rot);
    total_sum = {1'b0, total} + {{(TOTAL_W+1-ROOT_W){1'b0}}, sqrt_res.root};
  end

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_DIST_THR:  prdata = {{(PDATA_W-THR_W){1'b0}}, dist_thr};
      REG_ANGLE_COS: prdata = {{(PDATA_W-COS_W){1'b0}}, angle_cos};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr  <= DIST_THR_RST;
      angle_cos <= ANGLE_COS_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DIST_THR:  dist_thr  <= pwdata[THR_W-1:0];
        REG_ANGLE_COS: angle_cos <= pwdata[COS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_pending <= 1'b1;
      first_item    <= 1'b0;
      cnt           <= '0;
      total         <= '0;
      tr_v          <= 1'b0;
      abs_v         <= 1'b0;
      sq_v          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Load the result on a decision, drop it once taken
      if ((state == S_DECIDE) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pose.valid) begin
            rot_sr[0] <= pose.rot_00;
            rot_sr[1] <= pose.rot_01;
            rot_sr[2] <= pose.rot_02;
            rot_sr[3] <= pose.rot_10;
            rot_sr[4] <= pose.rot_11;
            rot_sr[5] <= pose.rot_12;
            rot_sr[6] <= pose.rot_20;
            rot_sr[7] <= pose.rot_21;
            rot_sr[8] <= pose.rot_22;
            pos_sr[0] <= pose.pos_x;
            pos_sr[1] <= pose.pos_y;
            pos_sr[2] <= pose.pos_z;
            first_item    <= first_pending;
            first_pending <= 1'b0;
            cnt    <= '0;
            tr_v   <= 1'b0;
            abs_v  <= 1'b0;
            sq_v   <= 1'b0;
            tr_acc <= '0;
            sq_acc <= '0;
            state  <= first_pending ? S_DECIDE : S_MAC;
          end
        end

        S_MAC: begin
          // Rotate rotation pairs through the trace multiplier
          tr_v <= (cnt < CNT_W'(NROT));
          if (cnt < CNT_W'(NROT)) begin
            tr_prod <= rot_sr[0] * key_rot[0];
            for (int i = 0; i < NROT - 1; i++) begin
              rot_sr[i]  <= rot_sr[i+1];
              key_rot[i] <= key_rot[i+1];
            end
            rot_sr[NROT-1]  <= rot_sr[0];
            key_rot[NROT-1] <= key_rot[0];
          end
          // Rotate translation pairs through the distance squarer
          abs_v <= (cnt < CNT_W'(NPOS));
          if (cnt < CNT_W'(NPOS)) begin
            absd <= pos_diff[POS_W] ? POS_W'(-pos_diff) : pos_diff[POS_W-1:0];
            for (int i = 0; i < NPOS - 1; i++) begin
              pos_sr[i]  <= pos_sr[i+1];
              key_pos[i] <= key_pos[i+1];
            end
            pos_sr[NPOS-1]  <= pos_sr[0];
            key_pos[NPOS-1] <= key_pos[0];
          end
          sq   <= absd * absd;
          sq_v <= abs_v;
          // Accumulate registered products
          if (tr_v) begin
            tr_acc <= tr_acc + {{(TR_W-PROD_W){tr_prod[PROD_W-1]}}, tr_prod};
          end
          if (sq_v) begin
            sq_acc <= sq_acc + {{(SQSUM_W-2*POS_W){1'b0}}, sq};
          end
          if (cnt == MAC_LAST) begin
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_ROOT: begin
          if (sqrt_res.done) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          // Hold until the output register is free
          if (out_free) begin
            if (take_pose) begin
              for (int i = 0; i < NROT; i++) begin
                key_rot[i] <= rot_sr[i];
              end
              for (int i = 0; i < NPOS; i++) begin
                key_pos[i] <= pos_sr[i];
              end
            end
            priority if (first_item || !take_pose) begin
              out_travelled <= total;
            end else if (total_sum[TOTAL_W]) begin
              total         <= '1;
              out_travelled <= '1;
            end else begin
              total         <= total_sum[TOTAL_W-1:0];
              out_travelled <= total_sum[TOTAL_W-1:0];
            end
            out_accepted <= take_pose;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid     = out_valid;
  assign result.accepted  = out_accepted;
  assign result.travelled = out_travelled;

  kmg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_acc),
    .res      (sqrt_res)
  );

endmodule

`default_nettype wire

// ===== sv/kmg_sqrt.sv =====
// ----------------------------------------------------------------------------
// kmg_sqrt
// Bit-serial floor square root: two radicand bits enter per cycle and one
// root bit leaves, restoring form.
// ----------------------------------------------------------------------------
`default_nettype none

module kmg_sqrt import kmg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SQSUM_W-1:0] radicand,
  output sqrt_res_t               res
);

  localparam int RAD_W  = 2 * ROOT_W;      // radicand padded to whole digits
  localparam int REM_W  = ROOT_W + 2;      // remainder never exceeds 2*root
  localparam int TRY_W  = REM_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_sr;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [TRY_W-1:0]  rem_shift;
  logic [TRY_W-1:0]  trial;

  // Form the trial remainder for the next root bit
  always_comb begin
    rem_shift = {rem, rad_sr[RAD_W-1 -: 2]};
    trial     = rem_shift - {2'b00, root, 2'b01};
  end

  // Shift the radicand and build the root one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(ROOT_W - 1);
        rad_sr <= {{(RAD_W-SQSUM_W){1'b0}}, radicand};
        rem    <= '0;
        root   <= '0;
      end else if (busy) begin
        rad_sr <= {rad_sr[RAD_W-3:0], 2'b00};
        if (!trial[TRY_W-1]) begin
          rem  <= trial[REM_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_shift[REM_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.root = root;

endmodule

`default_nettype wire

// ===== sim/keyframe_motion_gate_tb.sv =====
// ----------------------------------------------------------------------------
// keyframe_motion_gate_tb
// Self-checking bench for the keyframe motion gate. A scoreboard class holds
// an independent model of the gate: it predicts the decision and the running
// distance for every pose transaction and compares each result transaction
// with the oldest prediction. Stimulus is a directed burst of edge cases,
// then randomized phases of poses built around the current keyframe, near
// both thresholds, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_motion_gate_tb;
  import kmg_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 600;
  localparam int DRAIN_WAIT = 64;

  localparam logic [PADDR_W-1:0] ADDR_DIST_THR  = {REG_DIST_THR, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_ANGLE_COS = {REG_ANGLE_COS, 2'b00};

  localparam logic [ROT_W-1:0] Q_ONE     = 16'h4000;
  localparam logic [ROT_W-1:0] Q_NEG_ONE = 16'hC000;
  localparam logic [ROT_W-1:0] Q_ZERO    = 16'h0000;

  typedef struct packed {
    logic [8:0][ROT_W-1:0] rot;
    logic [2:0][POS_W-1:0] pos;
  } pose_t;

  typedef struct packed {
    logic               accepted;
    logic [TOTAL_W-1:0] travelled;
  } gate_out_t;

  // Model of the gate plus the queue of decisions still owed by the block
  class keyframe_scoreboard;
    bit                        first_pending;
    pose_t                     key;
    logic [TOTAL_W-1:0]        total;
    logic [THR_W-1:0]          dist_thr;
    logic signed [COS_W-1:0]   cos_thr;
    gate_out_t                 due_decisions[$];
    int                        errors;
    int                        n_checked;

    function new();
      first_pending = 1'b1;
      key           = '0;
      total         = '0;
      dist_thr      = DIST_THR_RST;
      cos_thr       = ANGLE_COS_RST;
      errors        = 0;
      n_checked     = 0;
    endfunction

    function int pending();
      return due_decisions.size();
    endfunction

    // Append one decision at the tail of the owed queue
    function void queue_decision(gate_out_t d);
      due_decisions = {due_decisions, d};
    endfunction

    function void set_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      if (addr[2] == REG_DIST_THR) begin
        dist_thr = data[THR_W-1:0];
      end else begin
        cos_thr = data[COS_W-1:0];
      end
    endfunction

    function void note_pose(pose_t p);
      logic signed [POS_W:0]   d;
      logic [POS_W:0]          mag;
      logic [SQSUM_W-1:0]      sq_sum;
      logic [ROOT_W-1:0]       root;
      logic [ROOT_W-1:0]       cand;
      logic [2*ROOT_W-1:0]     cand_sq;
      logic [TOTAL_W:0]        sum;
      longint                  trace;
      longint                  bound;
      bit                      take;

      // first pose after reset always becomes the keyframe
      if (first_pending) begin
        first_pending = 1'b0;
        key = p;
        queue_decision('{accepted: 1'b1, travelled: total});
        return;
      end

      // exact squared distance, then floor square root bit by bit
      sq_sum = '0;
      for (int i = 0; i < 3; i++) begin
        d = $signed(p.pos[i]) - $signed(key.pos[i]);
        mag = d[POS_W] ? -d : d;
        sq_sum += SQSUM_W'(mag) * SQSUM_W'(mag);
      end
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        cand = root | (ROOT_W'(1) << b);
        cand_sq = (2*ROOT_W)'(cand) * (2*ROOT_W)'(cand);
        if (cand_sq <= (2*ROOT_W)'(sq_sum)) root = cand;
      end

      // trace of key^T * new, Q4.28, against 1 + 2c
      trace = 0;
      for (int i = 0; i < 9; i++) begin
        trace += longint'($signed(p.rot[i])) * longint'($signed(key.rot[i]));
      end
      bound = (64'sd16384 + 2 * longint'(cos_thr)) * 64'sd16384;

      take = !((root < ROOT_W'(dist_thr)) && (trace > bound));
      if (take) begin
        sum = {1'b0, total} + (TOTAL_W+1)'(root);
        total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        key = p;
      end
      queue_decision('{accepted: take, travelled: total});
    endfunction

    function void check_result(logic acc, logic [TOTAL_W-1:0] trav);
      gate_out_t want;
      if (due_decisions.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with no pose pending: accepted=%0b travelled=%0d",
                   acc, trav);
        return;
      end
      want = due_decisions.pop_front();
      if (want.accepted !== acc || want.travelled !== trav) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: expected accepted=%0b travelled=%0d, got accepted=%0b travelled=%0d",
                   n_checked, want.accepted, want.travelled, acc, trav);
      end
      n_checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  kmg_pose_if   pose_ch ();
  kmg_result_if res_ch ();

  keyframe_scoreboard sb = new();

  bit src_steady       = 1'b0;
  bit snk_steady       = 1'b0;
  int long_holds_asked = 0;
  int long_holds_done  = 0;
  int hold_left        = 0;
  int stall_left       = 0;
  int idle_cycles      = 0;

  keyframe_motion_gate u_dut (
    .clk     (clk),
    .rst     (rst),
    .pose    (pose_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic pose_t uniform_pose(logic [ROT_W-1:0] diag, logic [ROT_W-1:0] off,
                                         logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                         logic [POS_W-1:0] z);
    pose_t p;
    for (int i = 0; i < 9; i++) p.rot[i] = (i % 4 == 0) ? diag : off;
    p.pos[0] = x;
    p.pos[1] = y;
    p.pos[2] = z;
    return p;
  endfunction

  // Build a pose relative to the current keyframe, aiming near both thresholds
  function automatic pose_t gen_pose();
    pose_t  p;
    real    kr[3][3];
    real    rr[3][3];
    real    acc;
    real    ang;
    real    thr_ang;
    real    c_norm;
    int     ax;
    int     u;
    int     v;
    int     mode;
    int     q;
    bit     fresh;
    longint mag;
    longint dlt[3];

    // noise: arbitrary bits everywhere
    if ($urandom_range(0, 99) < 12) begin
      for (int i = 0; i < 9; i++) p.rot[i] = ROT_W'($urandom);
      for (int i = 0; i < 3; i++) p.pos[i] = $urandom;
      return p;
    end

    // rotation: keyframe (or identity) turned about one axis
    fresh = sb.first_pending || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kr[i][j] = fresh ? ((i == j) ? 1.0 : 0.0) : $signed(sb.key.rot[3*i+j]) / 16384.0;
        rr[i][j] = (i == j) ? 1.0 : 0.0;
      end
    end
    c_norm = sb.cos_thr / 16384.0;
    if (c_norm > 1.0) c_norm = 1.0;
    if (c_norm < -1.0) c_norm = -1.0;
    thr_ang = $acos(c_norm);
    mode = $urandom_range(0, 9);
    if (mode < 4) ang = thr_ang * (0.9 + 0.2 * $urandom_range(0, 1000) / 1000.0);
    else if (mode < 7) ang = 0.0;
    else ang = 3.14159265 * $urandom_range(0, 1000) / 1000.0;
    ax = $urandom_range(0, 2);
    u = (ax + 1) % 3;
    v = (ax + 2) % 3;
    rr[u][u] = $cos(ang);
    rr[v][v] = $cos(ang);
    rr[u][v] = -$sin(ang);
    rr[v][u] = $sin(ang);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0.0;
        for (int k = 0; k < 3; k++) acc += kr[i][k] * rr[k][j];
        q = int'(acc * 16384.0);
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        p.rot[3*i+j] = ROT_W'(q);
      end
    end

    // translation: offset from keyframe position
    mag = longint'(sb.dist_thr);
    for (int i = 0; i < 3; i++) dlt[i] = 0;
    mode = $urandom_range(0, 9);
    if (mode >= 3 && mode <= 5) begin
      ax = $urandom_range(0, 2);
      dlt[ax] = mag + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) dlt[ax] = -dlt[ax];
    end else if (mode == 6) begin
      for (int i = 0; i < 3; i++) begin
        dlt[i] = longint'(mag / 1.7320508) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) dlt[i] = -dlt[i];
      end
    end else if (mode >= 7 && mode <= 8) begin
      for (int i = 0; i < 3; i++)
        dlt[i] = longint'($urandom) % (2 * mag + 9) - (mag + 4);
    end
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = (mode == 9) ? $urandom : POS_W'(longint'($signed(sb.key.pos[i])) + dlt[i]);
    end
    return p;
  endfunction

  task automatic drive_payload(pose_t p);
    pose_ch.rot_00 <= p.rot[0];
    pose_ch.rot_01 <= p.rot[1];
    pose_ch.rot_02 <= p.rot[2];
    pose_ch.rot_10 <= p.rot[3];
    pose_ch.rot_11 <= p.rot[4];
    pose_ch.rot_12 <= p.rot[5];
    pose_ch.rot_20 <= p.rot[6];
    pose_ch.rot_21 <= p.rot[7];
    pose_ch.rot_22 <= p.rot[8];
    pose_ch.pos_x  <= p.pos[0];
    pose_ch.pos_y  <= p.pos[1];
    pose_ch.pos_z  <= p.pos[2];
  endtask

  // Offer one pose and hold it until the transaction completes
  task automatic send_pose(pose_t p);
    int gap;
    gap = src_steady ? 0 : pick_idle();
    if (gap > 0) begin
      pose_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pose_ch.valid <= 1'b1;
    drive_payload(p);
    do @(posedge clk); while (!(pose_ch.valid && pose_ch.ready));
    sb.note_pose(p);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic end_burst();
    pose_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int n_items);
    repeat (n_items) send_pose(gen_pose());
    end_burst();
  endtask

  // Result side: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (long_holds_done != long_holds_asked) begin
      long_holds_done = long_holds_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!snk_steady && $urandom_range(0, 9) == 0) begin
      stall_left = pick_idle();
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.accepted, res_ch.travelled);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pose_ch.valid && pose_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("keyframe_motion_gate verification failed");
        $finish;
      end
    end
  end

  initial begin
    pose_t p;

    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    pose_ch.valid <= 1'b0;
    drive_payload('0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: first pose, distance edge, rotation, extremes, odd matrices
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 0, 0, 0));
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 0, 0, 0));
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 1023, 0, 0));
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 1024, 0, 0));
    p = uniform_pose(Q_ZERO, Q_ZERO, 1024, 0, 0);
    p.rot[1] = Q_NEG_ONE;
    p.rot[3] = Q_ONE;
    p.rot[8] = Q_ONE;
    send_pose(p);
    send_pose(uniform_pose(Q_ONE, Q_ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_pose(uniform_pose(Q_NEG_ONE, Q_NEG_ONE, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000));
    send_pose(uniform_pose(16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_pose(uniform_pose(16'h7FFF, 16'h7FFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_pose(uniform_pose(Q_ZERO, Q_ZERO, -1, 0, 1));
    send_pose(uniform_pose(Q_ZERO, Q_ZERO, -1, 0, 1));
    end_burst();

    // strict angle compare: trace equal to the bound still passes
    write_reg(ADDR_DIST_THR, 32'h7FFF_FFFF);
    write_reg(ADDR_ANGLE_COS, 32'd16384);
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 5, 5, 5));
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 5, 5, 5));
    end_burst();
    write_reg(ADDR_ANGLE_COS, 32'd16383);
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 5, 5, 5));
    end_burst();
    write_reg(ADDR_DIST_THR, 32'd0);
    send_pose(uniform_pose(Q_ONE, Q_ZERO, 5, 5, 5));
    end_burst();

    // Random phases over a spread of threshold settings
    write_reg(ADDR_DIST_THR, $urandom_range(256, 1 << 20));
    write_reg(ADDR_ANGLE_COS, 32'(int'($urandom_range(0, 32768)) - 16384));
    long_holds_asked++;
    run_phase(100);

    write_reg(ADDR_DIST_THR, 32'd0);
    write_reg(ADDR_ANGLE_COS, 32'd16384);
    src_steady = 1'b1;
    snk_steady = 1'b1;
    run_phase(100);
    src_steady = 1'b0;
    snk_steady = 1'b0;

    write_reg(ADDR_DIST_THR, 32'hFFFF_FFFF);
    write_reg(ADDR_ANGLE_COS, 32'hABCD_C000);
    run_phase(100);

    write_reg(ADDR_DIST_THR, $urandom_range(1, 64));
    write_reg(ADDR_ANGLE_COS, 32'd16383);
    src_steady = 1'b1;
    run_phase(100);
    src_steady = 1'b0;

    write_reg(ADDR_DIST_THR, $urandom);
    write_reg(ADDR_ANGLE_COS, {16'($urandom), 16'h8000});
    run_phase(100);

    write_reg(ADDR_DIST_THR, {1'b0, 31'($urandom)} >> $urandom_range(0, 20));
    write_reg(ADDR_ANGLE_COS, 32'(int'($urandom_range(0, 32768)) - 16384));
    snk_steady = 1'b1;
    run_phase(100);
    snk_steady = 1'b0;

    // Let any stray result show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("keyframe_motion_gate verification clean");
    end else begin
      if (sb.pending() != 0) $display("ERROR: %0d results never arrived", sb.pending());
      $display("keyframe_motion_gate verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/kmg_pkg.sv
sv/kmg_pose_if.sv
sv/kmg_result_if.sv
sv/kmg_sqrt.sv
sv/keyframe_motion_gate.sv
sim/keyframe_motion_gate_tb.sv
